/* src/knps_pkg.sv */
package knps_pkg;

	localparam int KEY_ROWS   = 64;
	localparam int POINT_ROWS = 1024;
	localparam int NAME_CHARS = 8;
	localparam int KEY_AW     = $clog2(KEY_ROWS);
	localparam int PT_AW      = $clog2(POINT_ROWS);
	localparam int KEY_CW     = $clog2(KEY_ROWS + 1);
	localparam int PT_CW      = $clog2(POINT_ROWS + 1);

	localparam logic [1:0] OP_KEY   = 2'd0;
	localparam logic [1:0] OP_POINT = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_REJECT   = 3'd1;
	localparam logic [2:0] ST_NO_CAT   = 3'd2;
	localparam logic [2:0] ST_NO_NAME  = 3'd3;
	localparam logic [2:0] ST_NO_POINT = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_KEY_RD,
		S_KEY_CMP,
		S_PT_RD,
		S_PT_SUB,
		S_PT_MUL,
		S_PT_CMP,
		S_BEST_RD,
		S_SQRT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} sqrt_ctl_t;

	function automatic logic allowed_char(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5f;
	endfunction

	function automatic logic name_ok(input logic [63:0] key);
		logic ended;
		logic ok;
		logic [7:0] c;
		ended = 1'b0;
		ok = 1'b1;
		for (int i = 0; i < 8; i++) begin
			c = key[63 - 8 * i -: 8];
			if (ended) begin
				if (c != 8'd0) ok = 1'b0;
			end else if (c == 8'd0) begin
				if (i == 0) ok = 1'b0;
				ended = 1'b1;
			end else if (i >= NAME_CHARS || !allowed_char(c)) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

/* src/knps_ram.sv */
module knps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* src/knps_sqrt.sv */
module knps_sqrt import knps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [49:0] value,
	output logic [24:0] root,
	output sqrt_ctl_t   ctl
);
	logic [49:0] rem_q;
	logic [49:0] res_q;
	logic [49:0] bit_q;
	logic        busy_q;
	logic [49:0] trial;

	assign trial = res_q + bit_q;
	assign root  = res_q[24:0];
	assign ctl   = {start, busy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[1:0] == 2'd1) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= 50'd1 << 48;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

/* src/keyed_nearest_point_search.sv */
// channel | signals                                          | direction
// in      | valid stall op name_key owner_index coord_* last  | into block
// out     | out_valid out_stall status point_index owner_out  | out of block
//         | near_x near_y near_z distance                     |
// load rows pass through a key name read and check, results held until taken
// a query reads and checks keys in turn until the name matches, then takes
// each point on a pass through the shared subtract, multiply and compare
// unit, then 25 root steps
// reset empties the catalog; stores keep undefined contents until loaded
// stall is high while an item is at work or a result is not yet taken
module keyed_nearest_point_search import knps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic [1:0]         op,
	input  logic [63:0]        name_key,
	input  logic [7:0]         owner_index,
	input  logic signed [23:0] coord_x,
	input  logic signed [23:0] coord_y,
	input  logic signed [23:0] coord_z,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [9:0]         point_index,
	output logic [7:0]         owner_out,
	output logic signed [23:0] near_x,
	output logic signed [23:0] near_y,
	output logic signed [23:0] near_z,
	output logic [24:0]        distance
);
	state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [63:0] key_q;
	logic [7:0]  own_q;
	logic signed [23:0] qx_q, qy_q, qz_q;
	logic        last_q;

	logic [KEY_CW-1:0] key_total_q;
	logic [PT_CW-1:0]  point_total_q;
	logic catalog_valid_q, load_clean_q, loading_q;

	logic [KEY_CW-1:0] kidx_q;
	logic [PT_CW-1:0]  pidx_q;
	logic [KEY_AW-1:0] hit_q;
	logic found_q;
	logic [PT_AW-1:0] best_row_q;
	logic [49:0] best_q;
	logic signed [24:0] dx_q, dy_q, dz_q;
	logic signed [49:0] sq_x, sq_y, sq_z;
	logic [49:0] dist_q;

	logic [63:0] key_rd;
	logic [7:0]  own_rd;
	logic [23:0] x_rd, y_rd, z_rd;

	logic key_we, pt_we;
	logic [KEY_AW-1:0] key_raddr;
	logic [PT_AW-1:0]  pt_raddr;

	logic sqrt_start;
	logic [24:0] root;
	sqrt_ctl_t sqrt_ctl;

	logic accept;
	assign accept = valid && !stall;
	assign stall  = (state_q != S_IDLE) || out_valid;

	// key index read at kidx during lookup, at previous key on key load
	assign key_raddr = (state_q == S_KEY_RD && op_q == OP_KEY) ?
		KEY_AW'(key_total_q - KEY_CW'(1)) : kidx_q[KEY_AW-1:0];
	assign pt_raddr = (state_q == S_BEST_RD || state_q == S_SQRT) ?
		best_row_q : pidx_q[PT_AW-1:0];

	logic lc_eff;
	logic [KEY_CW-1:0] kt_eff;
	logic [PT_CW-1:0]  pt_eff;
	assign lc_eff = loading_q ? load_clean_q : 1'b1;
	assign kt_eff = loading_q ? key_total_q : '0;
	assign pt_eff = loading_q ? point_total_q : '0;

	logic key_fail, pt_fail;
	assign key_fail = (kt_eff >= KEY_CW'(KEY_ROWS)) || !name_ok(key_q) ||
		(kt_eff != '0 && key_q <= key_rd);
	assign pt_fail = (pt_eff >= PT_CW'(POINT_ROWS)) || ({1'b0, own_q} >= 9'(kt_eff));
	assign key_we = (state_q == S_KEY_CMP) && op_q == OP_KEY && lc_eff && !key_fail;
	assign pt_we  = (state_q == S_KEY_CMP) && op_q == OP_POINT && lc_eff && !pt_fail;

	knps_ram #(.WIDTH(64), .DEPTH(KEY_ROWS)) u_keys (
		.clk(clk), .we(key_we), .waddr(kt_eff[KEY_AW-1:0]), .wdata(key_q),
		.raddr(key_raddr), .rdata(key_rd));
	knps_ram #(.WIDTH(8), .DEPTH(POINT_ROWS)) u_own (
		.clk(clk), .we(pt_we), .waddr(pt_eff[PT_AW-1:0]), .wdata(own_q),
		.raddr(pt_raddr), .rdata(own_rd));
	knps_ram #(.WIDTH(24), .DEPTH(POINT_ROWS)) u_xs (
		.clk(clk), .we(pt_we), .waddr(pt_eff[PT_AW-1:0]), .wdata(qx_q),
		.raddr(pt_raddr), .rdata(x_rd));
	knps_ram #(.WIDTH(24), .DEPTH(POINT_ROWS)) u_ys (
		.clk(clk), .we(pt_we), .waddr(pt_eff[PT_AW-1:0]), .wdata(qy_q),
		.raddr(pt_raddr), .rdata(y_rd));
	knps_ram #(.WIDTH(24), .DEPTH(POINT_ROWS)) u_zs (
		.clk(clk), .we(pt_we), .waddr(pt_eff[PT_AW-1:0]), .wdata(qz_q),
		.raddr(pt_raddr), .rdata(z_rd));

	assign sqrt_start = (state_q == S_BEST_RD);
	knps_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .value(best_q),
		.root(root), .ctl(sqrt_ctl));

	assign sq_x = dx_q * dx_q;
	assign sq_y = dy_q * dy_q;
	assign sq_z = dz_q * dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_KEY || op == OP_POINT) state_d = S_KEY_RD;
					else if (op == OP_QUERY) state_d = catalog_valid_q ? S_KEY_RD : S_DONE;
					else state_d = S_DONE;
				end
			end
			S_KEY_RD: state_d = S_KEY_CMP;
			S_KEY_CMP: begin
				if (op_q != OP_QUERY) state_d = S_DONE;
				else if (key_rd == key_q) state_d = S_PT_RD;
				else if (kidx_q + KEY_CW'(1) >= key_total_q) state_d = S_DONE;
				else state_d = S_KEY_RD;
			end
			S_PT_RD: state_d = (pidx_q >= point_total_q) ?
				(found_q ? S_BEST_RD : S_DONE) : S_PT_SUB;
			S_PT_SUB: state_d = S_PT_MUL;
			S_PT_MUL: state_d = S_PT_CMP;
			S_PT_CMP: state_d = S_PT_RD;
			S_BEST_RD: state_d = S_SQRT;
			S_SQRT: if (!sqrt_ctl.busy) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic [2:0] load_st;
	always_comb begin
		logic lc_new;
		lc_new = lc_eff && !(op_q == OP_KEY ? key_fail : pt_fail);
		load_st = lc_new ? ST_OK : ST_REJECT;
		if (last_q) load_st = (lc_new && (kt_eff + KEY_CW'(key_we)) != '0) ? ST_OK : ST_REJECT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_total_q     <= '0;
			point_total_q   <= '0;
			catalog_valid_q <= 1'b0;
			load_clean_q    <= 1'b1;
			loading_q       <= 1'b0;
			out_valid       <= 1'b0;
			found_q         <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == S_KEY_CMP && op_q != OP_QUERY) begin
				status <= load_st;
				if (last_q) begin
					loading_q <= 1'b0;
					load_clean_q <= 1'b1;
					catalog_valid_q <= (load_st == ST_OK);
					key_total_q <= (load_st == ST_OK) ? kt_eff + KEY_CW'(key_we) : '0;
					point_total_q <= (load_st == ST_OK) ? pt_eff + PT_CW'(pt_we) : '0;
				end else begin
					loading_q <= 1'b1;
					catalog_valid_q <= 1'b0;
					load_clean_q <= (load_st == ST_OK);
					key_total_q <= kt_eff + KEY_CW'(key_we);
					point_total_q <= pt_eff + PT_CW'(pt_we);
				end
			end
			if (state_q == S_IDLE && accept) begin
				found_q <= 1'b0;
				status <= ST_OK;
				if (op == OP_QUERY && (!catalog_valid_q || loading_q)) status <= ST_NO_CAT;
			end
			if (state_q == S_KEY_CMP && op_q == OP_QUERY) begin
				if (key_rd != key_q && kidx_q + KEY_CW'(1) >= key_total_q) status <= ST_NO_NAME;
			end
			if (state_q == S_PT_CMP && own_rd == 8'(hit_q)) begin
				if (!found_q || dist_q < best_q) begin
					found_q <= 1'b1;
					best_q <= dist_q;
					best_row_q <= pidx_q[PT_AW-1:0];
				end
			end
			if (state_q == S_PT_RD && pidx_q >= point_total_q && !found_q) status <= ST_NO_POINT;
			if (state_q == S_DONE) out_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			op_q <= op; key_q <= name_key; own_q <= owner_index;
			qx_q <= coord_x; qy_q <= coord_y; qz_q <= coord_z; last_q <= last;
			kidx_q <= '0; pidx_q <= '0;
			point_index <= '0; owner_out <= '0; near_x <= '0; near_y <= '0;
			near_z <= '0; distance <= '0;
		end
		if (state_q == S_KEY_CMP && op_q == OP_QUERY) begin
			if (key_rd == key_q) hit_q <= kidx_q[KEY_AW-1:0];
			else kidx_q <= kidx_q + KEY_CW'(1);
		end
		if (state_q == S_PT_SUB) begin
			dx_q <= 25'(signed'(x_rd)) - 25'(qx_q);
			dy_q <= 25'(signed'(y_rd)) - 25'(qy_q);
			dz_q <= 25'(signed'(z_rd)) - 25'(qz_q);
		end
		if (state_q == S_PT_MUL) begin
			dist_q <= unsigned'(sq_x) + unsigned'(sq_y) + unsigned'(sq_z);
		end
		if (state_q == S_PT_CMP) pidx_q <= pidx_q + PT_CW'(1);
		if (state_q == S_SQRT && !sqrt_ctl.busy) begin
			point_index <= 10'(best_row_q);
			owner_out <= own_rd; near_x <= x_rd; near_y <= y_rd; near_z <= z_rd;
			distance <= root;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> stall) else $error("accept while busy");
	a_keys_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_total_q <= KEY_CW'(KEY_ROWS)) else $error("key count overflow");
	a_pts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		point_total_q <= PT_CW'(POINT_ROWS)) else $error("point count overflow");
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(catalog_valid_q |-> !loading_q)) else $error("catalog valid during load");
endmodule
